[rtl/core/grck_pkg.sv]
// ----------------------------------------------------------------------------
// grck_pkg
// Shared widths, register indexes and types for the grid rank class key block.
// ----------------------------------------------------------------------------
package grck_pkg;

    localparam int RANK_W  = 30;
    localparam int KEY_W   = 30;
    localparam int SIZE_W  = 11;
    localparam int PLANE_W = 2 * SIZE_W;
    localparam int TOTAL_W = PLANE_W + SIZE_W;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    // clamped grid extents; user keeps static with items in flight; unchecked
    typedef struct packed {
        logic [SIZE_W-1:0] nx;
        logic [SIZE_W-1:0] ny;
        logic [SIZE_W-1:0] nz;
    } dims_t;

    // position class, in key order
    typedef enum logic [3:0] {
        CAT_CORNER,
        CAT_EDGE_X,
        CAT_EDGE_Y,
        CAT_EDGE_Z,
        CAT_FACE_ZL,
        CAT_FACE_ZH,
        CAT_FACE_YL,
        CAT_FACE_YH,
        CAT_FACE_XL,
        CAT_FACE_XH,
        CAT_INTERIOR
    } cat_t;

endpackage

[rtl/core/grck_div.sv]
// ----------------------------------------------------------------------------
// grck_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module grck_div #(
    parameter int NUM_W  = 30,
    parameter int DEN_W  = 22,
    parameter int Q_W    = 11,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [Q_W-1:0]    quo,
    output logic [((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W)-1:0] rem,
    output logic [SIDE_W-1:0] side_out
);

    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic              v_reg    [Q_W];
    logic [CW-1:0]     rem_reg  [Q_W];
    logic [Q_W-1:0]    quo_reg  [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];
    logic              adv      [Q_W];

    genvar s;
    generate
        for (s = 0; s < Q_W; s++) begin : g_stage
            localparam int B = Q_W - 1 - s;
            logic              v_p;
            logic [CW-1:0]     rem_p;
            logic [Q_W-1:0]    quo_p;
            logic [DEN_W-1:0]  den_p;
            logic [SIDE_W-1:0] side_p;
            logic [CW-1:0]     sh;
            logic              ge;
            logic [CW-1:0]     rem_next;
            logic [Q_W-1:0]    quo_next;

            if (s == 0) begin : g_first
                assign v_p    = in_valid;
                assign rem_p  = CW'(num);
                assign quo_p  = '0;
                assign den_p  = den;
                assign side_p = side_in;
            end
            else begin : g_rest
                assign v_p    = v_reg[s-1];
                assign rem_p  = rem_reg[s-1];
                assign quo_p  = quo_reg[s-1];
                assign den_p  = den_reg[s-1];
                assign side_p = side_reg[s-1];
            end

            if (s == Q_W - 1) begin : g_last_adv
                assign adv[s] = !v_reg[s] || out_ready;
            end
            else begin : g_mid_adv
                assign adv[s] = !v_reg[s] || adv[s+1];
            end

            always_comb
            begin
                sh       = CW'(den_p) << B;
                ge       = (rem_p >= sh);
                rem_next = ge ? (rem_p - sh) : rem_p;
                quo_next = quo_p;
                quo_next[B] = ge;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (adv[s])
                begin
                    v_reg[s] <= v_p;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[s])
                begin
                    rem_reg[s]  <= rem_next;
                    quo_reg[s]  <= quo_next;
                    den_reg[s]  <= den_p;
                    side_reg[s] <= side_p;
                end
            end
        end
    endgenerate

    assign in_ready  = adv[0];
    assign out_valid = v_reg[Q_W-1];
    assign quo       = quo_reg[Q_W-1];
    assign rem       = rem_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

[rtl/core/grck_class.sv]
// ----------------------------------------------------------------------------
// grck_class
// Four-stage classifier: coordinates to class key (class, products, sum).
// ----------------------------------------------------------------------------
module grck_class
    import grck_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [SIZE_W-1:0] x,
    input  logic [SIZE_W-1:0] y,
    input  logic [SIZE_W-1:0] z,
    input  logic              oog,
    input  dims_t             dims,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KEY_W-1:0]  class_key,
    output logic              out_of_grid
);

    // first matching (a,b) pair of (lo,lo),(lo,hi),(hi,lo),(hi,hi)
    function automatic logic [1:0] pair_idx(input logic al, input logic ah,
                                            input logic bl, input logic bh);
        logic [1:0] k;
        if (al && bl)      k = 2'd0;
        else if (al && bh) k = 2'd1;
        else if (ah && bl) k = 2'd2;
        else               k = 2'd3;
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] kmul(input logic [1:0] k,
                                              input logic [SIZE_W-1:0] e);
        logic [KEY_W-1:0] r;
        r = '0;
        if (k[1]) r = KEY_W'(e) << 1;
        if (k[0]) r = r + KEY_W'(e);
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] inner(input logic [SIZE_W-1:0] n);
        return (n > SIZE_W'(2)) ? n - SIZE_W'(2) : '0;
    endfunction

    logic adv1, adv2, adv3, adv4;

    // ---------------- stage 1: class and products
    logic               v1_reg, oog1_reg;
    cat_t               cat1_reg;
    logic [1:0]         k1_reg;
    logic [3:0]         ck1_reg, c1_reg;
    logic [SIZE_W-1:0]  xm1_reg, ym1_reg, zm1_reg, ex1_reg, ey1_reg, ez1_reg;
    logic [PLANE_W-1:0] pxy1_reg, pxz1_reg, pyz1_reg, exey1_reg, exez1_reg, eyez1_reg;

    logic lx, hx, ly, hy, lz, hz, xi, yi, zi;
    logic gx, gy, gz;
    logic [1:0] gsum;
    logic [SIZE_W-1:0] ex, ey, ez, xm, ym, zm;
    logic [3:0] ck_next, c_next;
    logic [1:0] k_next;
    cat_t cat_next;

    always_comb
    begin
        lx = (x == '0);
        hx = (x == dims.nx - SIZE_W'(1));
        ly = (y == '0);
        hy = (y == dims.ny - SIZE_W'(1));
        lz = (z == '0);
        hz = (z == dims.nz - SIZE_W'(1));
        xi = !lx && !hx;
        yi = !ly && !hy;
        zi = !lz && !hz;
        gx = (dims.nx > SIZE_W'(1));
        gy = (dims.ny > SIZE_W'(1));
        gz = (dims.nz > SIZE_W'(1));
        gsum = 2'(gx) + 2'(gy) + 2'(gz);
        c_next = 4'd1 << gsum;
        ck_next = (4'(!lx) << (2'(gy) + 2'(gz))) + (4'(!ly) << gz) + 4'(!lz);
        ex = inner(dims.nx);
        ey = inner(dims.ny);
        ez = inner(dims.nz);
        xm = x - SIZE_W'(1);
        ym = y - SIZE_W'(1);
        zm = z - SIZE_W'(1);
        k_next = 2'd0;
        if (!xi && !yi && !zi)
        begin
            cat_next = CAT_CORNER;
        end
        else if (xi && !yi && !zi)
        begin
            cat_next = CAT_EDGE_X;
            k_next   = pair_idx(ly, hy, lz, hz);
        end
        else if (yi && !xi && !zi)
        begin
            cat_next = CAT_EDGE_Y;
            k_next   = pair_idx(lx, hx, lz, hz);
        end
        else if (zi && !xi && !yi)
        begin
            cat_next = CAT_EDGE_Z;
            k_next   = pair_idx(lx, hx, ly, hy);
        end
        else if (xi && yi && lz) cat_next = CAT_FACE_ZL;
        else if (xi && yi && hz) cat_next = CAT_FACE_ZH;
        else if (xi && zi && ly) cat_next = CAT_FACE_YL;
        else if (xi && zi && hy) cat_next = CAT_FACE_YH;
        else if (yi && zi && lx) cat_next = CAT_FACE_XL;
        else if (yi && zi && hx) cat_next = CAT_FACE_XH;
        else                     cat_next = CAT_INTERIOR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv1)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            oog1_reg  <= oog;
            cat1_reg  <= cat_next;
            k1_reg    <= k_next;
            ck1_reg   <= ck_next;
            c1_reg    <= c_next;
            xm1_reg   <= xm;
            ym1_reg   <= ym;
            zm1_reg   <= zm;
            ex1_reg   <= ex;
            ey1_reg   <= ey;
            ez1_reg   <= ez;
            pxy1_reg  <= xm * ey;
            pxz1_reg  <= xm * ez;
            pyz1_reg  <= ym * ez;
            exey1_reg <= ex * ey;
            exez1_reg <= ex * ez;
            eyez1_reg <= ey * ez;
        end
    end

    // ---------------- stage 2: run offsets and key for all but interior
    logic               v2_reg, oog2_reg, int2_reg;
    logic [KEY_W-1:0]   base2_reg;
    logic [PLANE_W-1:0] ip2_reg;
    logic [SIZE_W-1:0]  ez2_reg;

    logic [KEY_W-1:0] f_base, e4x, e4y, exey_k, exez_k, eyez_k, base_next;

    always_comb
    begin
        e4x    = KEY_W'(ex1_reg) << 2;
        e4y    = KEY_W'(ey1_reg) << 2;
        exey_k = KEY_W'(exey1_reg);
        exez_k = KEY_W'(exez1_reg);
        eyez_k = KEY_W'(eyez1_reg);
        f_base = KEY_W'(c1_reg) + e4x + e4y + (KEY_W'(ez1_reg) << 2);
        unique case (cat1_reg)
            CAT_CORNER:  base_next = KEY_W'(ck1_reg);
            CAT_EDGE_X:  base_next = KEY_W'(c1_reg) + kmul(k1_reg, ex1_reg)
                                     + KEY_W'(xm1_reg);
            CAT_EDGE_Y:  base_next = KEY_W'(c1_reg) + e4x + kmul(k1_reg, ey1_reg)
                                     + KEY_W'(ym1_reg);
            CAT_EDGE_Z:  base_next = KEY_W'(c1_reg) + e4x + e4y
                                     + kmul(k1_reg, ez1_reg) + KEY_W'(zm1_reg);
            CAT_FACE_ZL: base_next = f_base + KEY_W'(pxy1_reg) + KEY_W'(ym1_reg);
            CAT_FACE_ZH: base_next = f_base + exey_k + KEY_W'(pxy1_reg)
                                     + KEY_W'(ym1_reg);
            CAT_FACE_YL: base_next = f_base + (exey_k << 1) + KEY_W'(pxz1_reg)
                                     + KEY_W'(zm1_reg);
            CAT_FACE_YH: base_next = f_base + (exey_k << 1) + exez_k
                                     + KEY_W'(pxz1_reg) + KEY_W'(zm1_reg);
            CAT_FACE_XL: base_next = f_base + ((exey_k + exez_k) << 1)
                                     + KEY_W'(pyz1_reg) + KEY_W'(zm1_reg);
            CAT_FACE_XH: base_next = f_base + ((exey_k + exez_k) << 1) + eyez_k
                                     + KEY_W'(pyz1_reg) + KEY_W'(zm1_reg);
            default:     base_next = f_base + ((exey_k + exez_k + eyez_k) << 1)
                                     + KEY_W'(zm1_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            oog2_reg  <= oog1_reg;
            int2_reg  <= (cat1_reg == CAT_INTERIOR);
            base2_reg <= base_next;
            ip2_reg   <= pxy1_reg + PLANE_W'(ym1_reg);
            ez2_reg   <= ez1_reg;
        end
    end

    // ---------------- stage 3: interior product
    logic             v3_reg, oog3_reg, int3_reg;
    logic [KEY_W-1:0] base3_reg, iprod3_reg;
    logic [TOTAL_W-1:0] iprod_full;

    assign iprod_full = ip2_reg * ez2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            oog3_reg   <= oog2_reg;
            int3_reg   <= int2_reg;
            base3_reg  <= base2_reg;
            iprod3_reg <= iprod_full[KEY_W-1:0];
        end
    end

    // ---------------- stage 4: final sum, output register
    logic             v4_reg, oog4_reg;
    logic [KEY_W-1:0] key4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv4)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            oog4_reg <= oog3_reg;
            key4_reg <= oog3_reg ? '0
                      : (base3_reg + (int3_reg ? iprod3_reg : '0));
        end
    end

    assign adv4 = !v4_reg || out_ready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign in_ready    = adv1;
    assign out_valid   = v4_reg;
    assign class_key   = key4_reg;
    assign out_of_grid = oog4_reg;

endmodule

[rtl/core/grid_rank_class_key.sv]
// ----------------------------------------------------------------------------
// grid_rank_class_key
// Splits a linear rank into 3D grid coordinates and returns its class key.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                   payload
//  rank      in   rank_valid / rank_ready     rank_in[29:0]
//  result    out  result_valid / result_ready class_key[29:0], out_of_grid
//  config    in   cfg_we (no wait)            cfg_index[1:0], cfg_data[10:0]
//
//  A rank passes two front stages (plane size, grid bound), 11 stages of
//  the z divider, 11 of the x/y divider and four classifier stages. One
//  transaction per cycle while result_ready does not stall the pipeline.
//  Reset clears the valid bits and sets all three extents to 1.
//  Every stage holds while the one after it is full and stalled, so bubbles
//  close up and ready reaches back combinationally from result_ready.
//
module grid_rank_class_key
    import grck_pkg::*;
#(
    parameter int MAX_DIM = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 rank_valid,
    output logic                 rank_ready,
    input  logic [RANK_W-1:0]    rank_in,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [KEY_W-1:0]     class_key,
    output logic                 out_of_grid
);

    // extents above this are treated as this
    localparam int CLAMP = (MAX_DIM > (1 << SIZE_W) - 1) ? (1 << SIZE_W) - 1 : MAX_DIM;
    localparam logic [SIZE_W-1:0] CLAMP_V = SIZE_W'(CLAMP);

    // ---------------- configuration registers
    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_W'(1);
            size_y_reg <= SIZE_W'(1);
            size_z_reg <= SIZE_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SIZE_X: size_x_reg <= cfg_data;
                REG_SIZE_Y: size_y_reg <= cfg_data;
                REG_SIZE_Z: size_z_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    dims_t dims;
    assign dims.nx = (size_x_reg > CLAMP_V) ? CLAMP_V : size_x_reg;
    assign dims.ny = (size_y_reg > CLAMP_V) ? CLAMP_V : size_y_reg;
    assign dims.nz = (size_z_reg > CLAMP_V) ? CLAMP_V : size_z_reg;

    // an extent of zero means an empty grid
    logic empty_grid;
    assign empty_grid = (dims.nx == '0) || (dims.ny == '0) || (dims.nz == '0);

    // ---------------- front stage 0: plane size nx*ny
    logic               f0_v_reg;
    logic [RANK_W-1:0]  f0_rank_reg;
    logic [PLANE_W-1:0] f0_plane_reg;
    logic               f0_adv;

    // ---------------- front stage 1: grid bound check
    logic               f1_v_reg;
    logic [RANK_W-1:0]  f1_rank_reg;
    logic [PLANE_W-1:0] f1_plane_reg;
    logic               f1_oog_reg;
    logic               f1_adv;
    logic [TOTAL_W-1:0] total;

    assign total = f0_plane_reg * dims.nz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_v_reg <= 1'b0;
            f1_v_reg <= 1'b0;
        end
        else
        begin
            if (f0_adv)
            begin
                f0_v_reg <= rank_valid;
            end
            if (f1_adv)
            begin
                f1_v_reg <= f0_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (f0_adv)
        begin
            f0_rank_reg  <= rank_in;
            f0_plane_reg <= dims.nx * dims.ny;
        end
        if (f1_adv)
        begin
            f1_rank_reg  <= f0_rank_reg;
            f1_plane_reg <= f0_plane_reg;
            f1_oog_reg   <= empty_grid || (TOTAL_W'(f0_rank_reg) >= total);
        end
    end

    // ---------------- z = rank / plane, remainder carries on
    localparam int D1_CW = TOTAL_W;

    logic               d1_in_ready, d1_valid, d1_oog;
    logic [SIZE_W-1:0]  d1_z;
    logic [D1_CW-1:0]   d1_rem;
    logic               d2_in_ready;

    assign f1_adv = !f1_v_reg || d1_in_ready;
    assign f0_adv = !f0_v_reg || f1_adv;
    assign rank_ready = f0_adv;

    grck_div #(
        .NUM_W  (RANK_W),
        .DEN_W  (PLANE_W),
        .Q_W    (SIZE_W),
        .SIDE_W (1)
    ) u_div_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f1_v_reg),
        .in_ready  (d1_in_ready),
        .num       (f1_rank_reg),
        .den       (f1_plane_reg),
        .side_in   (f1_oog_reg),
        .out_valid (d1_valid),
        .out_ready (d2_in_ready),
        .quo       (d1_z),
        .rem       (d1_rem),
        .side_out  (d1_oog)
    );

    // ---------------- y = rem / nx, x = rem mod nx
    logic                d2_valid, d2_oog, cl_in_ready;
    logic [SIZE_W-1:0]   d2_y, d2_z;
    logic [PLANE_W-1:0]  d2_rem;

    grck_div #(
        .NUM_W  (PLANE_W),
        .DEN_W  (SIZE_W),
        .Q_W    (SIZE_W),
        .SIDE_W (SIZE_W + 1)
    ) u_div_xy (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_valid),
        .in_ready  (d2_in_ready),
        .num       (d1_rem[PLANE_W-1:0]),
        .den       (dims.nx),
        .side_in   ({d1_z, d1_oog}),
        .out_valid (d2_valid),
        .out_ready (cl_in_ready),
        .quo       (d2_y),
        .rem       (d2_rem),
        .side_out  ({d2_z, d2_oog})
    );

    // ---------------- classifier and output register
    grck_class u_class (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (d2_valid),
        .in_ready    (cl_in_ready),
        .x           (d2_rem[SIZE_W-1:0]),
        .y           (d2_y),
        .z           (d2_z),
        .oog         (d2_oog),
        .dims        (dims),
        .out_valid   (result_valid),
        .out_ready   (result_ready),
        .class_key   (class_key),
        .out_of_grid (out_of_grid)
    );

    // ---------------- assertions
    a_oog_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_of_grid |-> class_key == '0)
        else $error("out of grid result with nonzero key");

    a_z_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        d1_valid && !d1_oog |-> d1_z < dims.nz)
        else $error("z divider quotient beyond grid");

    a_xy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        d2_valid && !d2_oog |-> (d2_rem < PLANE_W'(dims.nx)) && (d2_y < dims.ny))
        else $error("x/y divider result beyond grid");

endmodule
